### design/psc_pkg.sv
// Shared types for the prime sieve chain: per-stage control and status.
package psc_pkg;

	typedef struct packed {
		logic clr_all;   // drop every held prime
		logic start;     // clear the running remainder
		logic step;      // fold one candidate bit into the remainder
		logic data_bit;  // candidate bit, most significant first
		logic store;     // write the candidate into the first free stage
	} stage_ctl_t;

	typedef struct packed {
		logic valid;     // stage holds a prime
		logic hit;       // held prime divides the candidate
	} stage_sts_t;

endpackage

### design/prime_sieve_chain_top.sv
// Top level of the prime sieve chain: input control, stage chain, result register.
//
// Input channel (in_valid/in_ready) takes a candidate value and an end_of_stream
// flag; output channel (out_valid/out_ready) returns prime, unverified, done_res.
// A candidate is shifted most significant bit first into all STAGES stages at
// once; each stage keeps a running remainder by its held prime, one bit a cycle.
// A candidate passes a load step, VALUE_BITS remainder steps and a decide step
// before the next candidate can transfer. Its result, if any, shows on out_valid
// at the end of the decide cycle. End of stream and values below two skip the
// remainder steps. A prime no stage divides goes into the lowest free stage; with
// every stage full it is sent with unverified set. Divisible candidates and values
// below two give no result. End of stream clears all stages and sends one done
// result. Reset empties every stage and the result register. While the receiver
// stalls the result holds in its register; the block keeps taking items, and the
// first one that gives a result waits in the decide cycle until the register frees.
module prime_sieve_chain_top #(
	parameter int STAGES     = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] value,
	input  logic        end_of_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] prime,
	output logic        unverified,
	output logic        done_res
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] sreg_q;
	logic                  eos_q;
	logic                  drop_q;
	logic                  out_valid_q;
	logic [15:0]           prime_q;
	logic                  unverified_q;
	logic                  done_q;

	logic [VALUE_BITS-1:0] cand_in;
	logic                  in_xfer;
	logic                  divisible;
	logic                  full;
	logic                  emit;
	logic                  slot_free;
	logic                  fire;
	logic [STAGES-1:0]     valid_vec;
	logic [STAGES-1:0]     hit_vec;

	psc_pkg::stage_ctl_t   ctl;
	psc_pkg::stage_sts_t   sts [STAGES];

	assign cand_in   = VALUE_BITS'(value);
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign divisible = |hit_vec;
	assign full      = valid_vec[STAGES-1];
	assign emit      = eos_q || (!drop_q && !divisible);
	assign slot_free = !out_valid_q || out_ready;
	assign fire      = (state_q == ST_DONE) && emit && slot_free;

	always_comb begin
		ctl.clr_all  = in_xfer && end_of_stream;
		ctl.start    = in_xfer;
		ctl.step     = (state_q == ST_RUN);
		ctl.data_bit = sreg_q[VALUE_BITS-1];
		ctl.store    = fire && !eos_q;
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic prev_valid;
		if (i == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = valid_vec[i-1];
		end

		psc_stage #(
			.VALUE_BITS(VALUE_BITS)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.cand      (cand_q),
			.prev_valid(prev_valid),
			.sts       (sts[i])
		);

		assign valid_vec[i] = sts[i].valid;
		assign hit_vec[i]   = sts[i].hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						if (end_of_stream || (cand_in[VALUE_BITS-1:1] == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the result register can take the result
					if (!emit || slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cand_q <= cand_in;
			sreg_q <= cand_in;
			eos_q  <= end_of_stream;
			drop_q <= (cand_in[VALUE_BITS-1:1] == '0);
		end else if (state_q == ST_RUN) begin
			sreg_q <= {sreg_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			prime_q      <= eos_q ? 16'h0000 : 16'(cand_q);
			unverified_q <= !eos_q && full;
			done_q       <= eos_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign prime      = prime_q;
	assign unverified = unverified_q;
	assign done_res   = done_q;

	// stages fill from the bottom, so the valid bits always form a prefix
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + STAGES'(1)) & valid_vec) == '0)
		else $error("stage valid bits are not a prefix");

	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && end_of_stream) |=> (valid_vec == '0))
		else $error("end of stream left a stage valid");

	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> ((prime == 16'h0000) && !unverified))
		else $error("done result carries a prime or unverified flag");

	a_no_store_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> ($stable(valid_vec) || (state_q == ST_DONE)))
		else $error("stage contents changed during remainder steps");

endmodule

### design/psc_stage.sv
// One sieve stage: a held prime and a bit-serial remainder of the candidate.
module psc_stage #(
	parameter int VALUE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  psc_pkg::stage_ctl_t     ctl,
	input  logic [VALUE_BITS-1:0]   cand,
	input  logic                    prev_valid,
	output psc_pkg::stage_sts_t     sts
);

	logic                  valid_q;
	logic [VALUE_BITS-1:0] prime_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   divisor;
	logic [VALUE_BITS:0]   reduced;

	// r = 2r + bit, then one conditional subtract keeps r below the prime
	assign shifted = {rem_q, ctl.data_bit};
	assign divisor = {1'b0, prime_q};
	assign reduced = (shifted >= divisor) ? (shifted - divisor) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr_all) begin
			valid_q <= 1'b0;
		end else if (ctl.store && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.store && !valid_q && prev_valid) begin
			prime_q <= cand;
		end
		if (ctl.start) begin
			rem_q <= '0;
		end else if (ctl.step) begin
			rem_q <= reduced[VALUE_BITS-1:0];
		end
	end

	assign sts.valid = valid_q;
	assign sts.hit   = valid_q && (rem_q == '0);

endmodule
